### design/gdbd_pkg.sv
// gdbd_pkg: shared constants, types and the month length table for the
// gregorian days-between-dates unit. No dependencies.
package gdbd_pkg;

	// field widths and word layout
	localparam int YEAR_BITS_DEF = 14;
	localparam int FIELD_YEAR_W  = 14;
	localparam int MONTH_W       = 4;
	localparam int DAY_W         = 5;
	localparam int COUNT_W       = 23;
	localparam int S_DATA_W      = 48;
	localparam int M_DATA_W      = 24;

	localparam int OFF_Y1 = 0;
	localparam int OFF_M1 = OFF_Y1 + FIELD_YEAR_W;
	localparam int OFF_D1 = OFF_M1 + MONTH_W;
	localparam int OFF_Y2 = OFF_D1 + DAY_W;
	localparam int OFF_M2 = OFF_Y2 + FIELD_YEAR_W;
	localparam int OFF_D2 = OFF_M2 + MONTH_W;
	localparam int S_USED_W = OFF_D2 + DAY_W;

	// result limits
	localparam int COUNT_MAX = 4194303;
	localparam int COUNT_MIN = -31;

	// calendar constants
	localparam int DAYS_PER_YEAR = 365;
	localparam int DEC_DAYS      = 31;
	localparam int LAST_MONTH    = 12;

	// reciprocal of 25 for (n/4)/25 = n/100, exact for quotients below 2^14
	localparam int RECIP_W     = 16;
	localparam int RECIP_25    = 41944;
	localparam int RECIP_SHIFT = 20;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LMUL,
		ST_LADD,
		ST_YMUL,
		ST_BASE,
		ST_YADD,
		ST_WALKA,
		ST_WALKB,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ORD_SAME,
		ORD_BEFORE,
		ORD_AFTER
	} order_t;

	// days in month m, zero for codes outside january to december
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                   len = DAY_W'(30);
			4'd2:                                      len = DAY_W'(28) + DAY_W'(leap);
			default:                                   len = '0;
		endcase
		return len;
	endfunction

endpackage

### design/gdbd_mul.sv
// gdbd_mul: the shared registered multiplier of the days-between-dates unit,
// used for the divide-by-100 reciprocal and for whole years times 365.
// Depends on nothing.
module gdbd_mul #(
	parameter int A_W = 14,
	parameter int B_W = 16
) (
	input  logic               clk,
	input  logic               en,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] p
);

	logic [A_W+B_W-1:0] p_q;

	// product register, loaded only when the sequencer asks
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
		end
	end

	assign p = p_q;

endmodule

### design/gregorian_days_between_dates_unit.sv
// gregorian_days_between_dates_unit: top level, sequencer and accumulator.
// Depends on gdbd_pkg and gdbd_mul.
//
// Returns the signed number of days from the first date to the second
// (0 when the first year is later, saturated at 4194303). One word is taken
// at a time: after acceptance s_tready stays low until the result has been
// loaded into the output register. The work runs on one shared multiplier
// and one accumulating adder: four leap-year counts, each a multiply step and
// an add step, a multiply step for years times 365, one accumulate step (two
// across years), then a step per month walked in each year walked plus a
// closing step for each, and a step to load the result. A first year later
// than the second goes straight to the load step. The next word is taken in
// the cycle after the load at the earliest, and a stalled output holds the
// unit in its load step.
module gregorian_days_between_dates_unit #(
	parameter int YEAR_BITS = gdbd_pkg::YEAR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// fields from bit 0: first_year, first_month, first_day,
	// second_year, second_month, second_day, zero fill
	input  logic [gdbd_pkg::S_DATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// fields from bit 0: day_count (signed), zero fill
	output logic [gdbd_pkg::M_DATA_W-1:0] m_tdata
);
	import gdbd_pkg::*;

	localparam int YW = (YEAR_BITS < FIELD_YEAR_W) ? YEAR_BITS : FIELD_YEAR_W;
	localparam int PW = YW + RECIP_W;
	localparam int AW = YW + 11;

	state_t state_q, state_d;
	order_t order_q;

	logic [YW-1:0]      y1_q, y2_q;
	logic [MONTH_W-1:0] m1_q, m2_q, mon_q;
	logic [DAY_W-1:0]   d1_q, d2_q;
	logic [1:0]         lidx_q;
	logic [YW-1:0]      lcnt_q [4];
	logic signed [AW-1:0] acc_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_data_q;

	logic [YW-1:0]      in_y1, in_y2;
	logic               accept;

	logic               mul_en;
	logic [YW-1:0]      mul_a;
	logic [RECIP_W-1:0] mul_b;
	logic [PW-1:0]      prod;

	logic [YW-1:0]      n_sel, q_ext, h_val, lval;
	logic               leap1, leap2, cur_leap;
	logic [MONTH_W-1:0] walk_lim;
	logic               walk_go;
	logic signed [AW-1:0] base_s, term, acc_sum;
	logic               acc_en, load_out;
	logic signed [31:0] acc_w;
	logic [COUNT_W-1:0] sat_val;

	// input word fields, years cut to the used width
	assign in_y1  = s_tdata[OFF_Y1 +: YW];
	assign in_y2  = s_tdata[OFF_Y2 +: YW];
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// year argument of the current leap count: y1-1, y1, y2-1, y2
	always_comb begin
		case (lidx_q)
			2'd0:    n_sel = y1_q - YW'(1);
			2'd1:    n_sel = y1_q;
			2'd2:    n_sel = y2_q - YW'(1);
			default: n_sel = y2_q;
		endcase
	end

	// leap years up to n: n/4 - n/100 + n/400 from the registered product
	assign q_ext = n_sel >> 2;
	assign h_val = YW'(prod >> RECIP_SHIFT);
	assign lval  = q_ext - h_val + (h_val >> 2);

	// leap flags from consecutive counts, year zero counts as leap
	assign leap1 = (y1_q == '0) || (lcnt_q[1] != lcnt_q[0]);
	assign leap2 = (lcnt_q[3] != lcnt_q[2]);

	// shared multiplier operands
	assign mul_a = (state_q == ST_YMUL) ? (y2_q - y1_q - YW'(1)) : q_ext;
	assign mul_b = (state_q == ST_YMUL) ? RECIP_W'(DAYS_PER_YEAR) : RECIP_W'(RECIP_25);

	gdbd_mul #(
		.A_W(YW),
		.B_W(RECIP_W)
	) u_mul (
		.clk(clk),
		.en (mul_en),
		.a  (mul_a),
		.b  (mul_b),
		.p  (prod)
	);

	// starting value: rest of december and leap days in between, or d2 - d1
	always_comb begin
		if (order_q == ORD_BEFORE) begin
			base_s = AW'(DEC_DAYS) - AW'(d1_q) + AW'(d2_q) + AW'(lcnt_q[2] - lcnt_q[1]);
		end else begin
			base_s = AW'(d2_q) - AW'(d1_q);
		end
	end

	// month walk limit and leap flag of the year being walked
	assign walk_lim = (state_q == ST_WALKB) ? m2_q
		: ((order_q == ORD_BEFORE) ? MONTH_W'(LAST_MONTH) : m2_q);
	assign cur_leap = (state_q == ST_WALKB) ? leap2 : leap1;
	assign walk_go  = (mon_q < walk_lim);

	// saturation of the final count
	assign acc_w   = 32'(acc_q);
	assign sat_val = (acc_w > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : acc_q[COUNT_W-1:0];

	// shared accumulating adder
	assign acc_sum = acc_q + term;

	// next state and datapath enables
	always_comb begin
		state_d  = state_q;
		mul_en   = 1'b0;
		acc_en   = 1'b0;
		term     = '0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (in_y1 > in_y2) ? ST_DONE : ST_LMUL;
				end
			end
			ST_LMUL: begin
				mul_en  = 1'b1;
				state_d = ST_LADD;
			end
			ST_LADD: begin
				state_d = (lidx_q == 2'd3) ? ST_YMUL : ST_LMUL;
			end
			ST_YMUL: begin
				mul_en  = 1'b1;
				state_d = ST_BASE;
			end
			ST_BASE: begin
				acc_en  = 1'b1;
				term    = base_s;
				state_d = (order_q == ORD_BEFORE) ? ST_YADD : ST_WALKA;
			end
			ST_YADD: begin
				acc_en  = 1'b1;
				term    = AW'(prod[AW-2:0]);
				state_d = ST_WALKA;
			end
			ST_WALKA: begin
				if (walk_go) begin
					acc_en = 1'b1;
					term   = AW'(month_len(mon_q, cur_leap));
				end else begin
					state_d = (order_q == ORD_BEFORE) ? ST_WALKB : ST_DONE;
				end
			end
			ST_WALKB: begin
				if (walk_go) begin
					acc_en = 1'b1;
					term   = AW'(month_len(mon_q, cur_leap));
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// operand capture, leap counts, month counter and accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			y1_q    <= in_y1;
			y2_q    <= in_y2;
			m1_q    <= s_tdata[OFF_M1 +: MONTH_W];
			d1_q    <= s_tdata[OFF_D1 +: DAY_W];
			m2_q    <= s_tdata[OFF_M2 +: MONTH_W];
			d2_q    <= s_tdata[OFF_D2 +: DAY_W];
			order_q <= (in_y1 == in_y2) ? ORD_SAME
				: ((in_y1 < in_y2) ? ORD_BEFORE : ORD_AFTER);
			acc_q   <= '0;
			lidx_q  <= '0;
		end else begin
			if (acc_en) begin
				acc_q <= acc_sum;
			end
			if (state_q == ST_LADD) begin
				lcnt_q[lidx_q] <= lval;
				lidx_q         <= lidx_q + 2'd1;
			end
			if (state_q == ST_BASE || state_q == ST_YADD) begin
				mon_q <= m1_q;
			end else if ((state_q == ST_WALKA || state_q == ST_WALKB) && walk_go) begin
				mon_q <= mon_q + MONTH_W'(1);
			end else if (state_q == ST_WALKA) begin
				mon_q <= MONTH_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= sat_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'(out_data_q);

	// checks
	logic signed [COUNT_W-1:0] out_s;
	assign out_s = out_data_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready high right after a word was taken");

	a_later_first_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (in_y1 > in_y2)) |=> (state_q == ST_DONE && acc_q == '0))
		else $error("later first year did not clear the count");

	a_years_after_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_YMUL) |-> ($past(state_q) == ST_LADD && $past(lidx_q) == 2'd3))
		else $error("year product started before all leap counts");

	a_count_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_s >= COUNT_MIN))
		else $error("day count below the smallest possible value");

endmodule

### tb/gdbd_day_count_checker.sv
// gdbd_day_count_checker: watches both stream channels of the days-between-dates
// unit, predicts each day count and compares it with the returned word.
// Depends on gdbd_pkg for field offsets and widths.
module gdbd_day_count_checker #(
	parameter int YEAR_BITS = gdbd_pkg::YEAR_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	// fields from bit 0: first_year, first_month, first_day,
	// second_year, second_month, second_day, zero fill
	input  logic [gdbd_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	// fields from bit 0: day_count (signed), zero fill
	input  logic [gdbd_pkg::M_DATA_W-1:0] m_tdata,
	output int                            mismatches,
	output int                            pending
);
	import gdbd_pkg::*;

	// day counts still owed by the unit, oldest first
	logic [COUNT_W-1:0] owed_counts[$];

	function automatic longint is_leap(input longint y);
		return ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 1 : 0;
	endfunction

	// leap years in 1..n
	function automatic longint leaps_through(input longint n);
		return n / 4 - n / 100 + n / 400;
	endfunction

	function automatic longint month_days(input longint m, input longint leap);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return 28 + leap;
			default:               return 0;
		endcase
	endfunction

	// months ma up to mb (exclusive), less the first day, plus the second
	function automatic longint months_span(input longint ma, input longint da,
			input longint mb, input longint db, input longint leap);
		longint total;
		total = 0;
		for (longint m = ma; m < mb; m++)
			total += month_days(m, leap);
		return total - da + db;
	endfunction

	function automatic logic [COUNT_W-1:0] days_between(input logic [S_DATA_W-1:0] w);
		longint ymask, y1, m1, d1, y2, m2, d2, days;
		ymask = (longint'(1) << YEAR_BITS) - 1;
		y1 = longint'(w[OFF_Y1 +: FIELD_YEAR_W]) & ymask;
		m1 = longint'(w[OFF_M1 +: MONTH_W]);
		d1 = longint'(w[OFF_D1 +: DAY_W]);
		y2 = longint'(w[OFF_Y2 +: FIELD_YEAR_W]) & ymask;
		m2 = longint'(w[OFF_M2 +: MONTH_W]);
		d2 = longint'(w[OFF_D2 +: DAY_W]);
		days = 0;
		if (y1 == y2) begin
			days = months_span(m1, d1, m2, d2, is_leap(y1));
		end else if (y1 < y2) begin
			// rest of the first year, then the elapsed part of the second
			days = months_span(m1, d1, 12, 31, is_leap(y1)) + 1;
			days += months_span(1, 1, m2, d2, is_leap(y2));
			// whole years in between
			if (y2 - y1 > 1)
				days += (y2 - 1 - y1) * 365 + leaps_through(y2 - 1) - leaps_through(y1);
		end
		if (days > COUNT_MAX)
			days = COUNT_MAX;
		return COUNT_W'(days);
	endfunction

	// pop on each result word, then push on each date word
	always @(posedge clk or negedge arst_n) begin
		logic [M_DATA_W-1:0] want;
		if (!arst_n) begin
			owed_counts.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (owed_counts.size() == 0) begin
					$display("%0t: unexpected result word, expected none, got %0d (word %h)",
						$time, $signed(m_tdata[COUNT_W-1:0]), m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					want = M_DATA_W'(owed_counts.pop_front());
					if (m_tdata !== want) begin
						$display("%0t: day_count mismatch, expected %0d (word %h), got %0d (word %h)",
							$time, $signed(want[COUNT_W-1:0]), want,
							$signed(m_tdata[COUNT_W-1:0]), m_tdata);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				owed_counts.push_back(days_between(s_tdata));
			pending <= owed_counts.size();
		end
	end

endmodule

### tb/gregorian_days_between_dates_unit_tb.sv
// gregorian_days_between_dates_unit_tb: drives date pairs into the unit with
// random sender gaps and receiver stalls, and reports the verdict.
// Depends on gdbd_pkg, the unit itself and gdbd_day_count_checker.
module gregorian_days_between_dates_unit_tb;
	import gdbd_pkg::*;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 60;
	localparam int ITEMS_PER_PHASE = 217;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int mismatches;
	int pending;
	int send_idle_pct = 6;
	int recv_idle_pct = 78;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	gregorian_days_between_dates_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	gdbd_day_count_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// receiver stalls at the current rate
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// watchdog: cycles with no word moved on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [S_DATA_W-1:0] pack_dates(input int y1, input int m1,
			input int d1, input int y2, input int m2, input int d2);
		logic [S_DATA_W-1:0] w;
		w = '0;
		w[OFF_Y1 +: FIELD_YEAR_W] = FIELD_YEAR_W'(y1);
		w[OFF_M1 +: MONTH_W]      = MONTH_W'(m1);
		w[OFF_D1 +: DAY_W]        = DAY_W'(d1);
		w[OFF_Y2 +: FIELD_YEAR_W] = FIELD_YEAR_W'(y2);
		w[OFF_M2 +: MONTH_W]      = MONTH_W'(m2);
		w[OFF_D2 +: DAY_W]        = DAY_W'(d2);
		return w;
	endfunction

	// mostly real dates in order, some out-of-range codes and raw bit patterns
	function automatic logic [S_DATA_W-1:0] random_dates();
		int kind, gap, y1, y2;
		logic [S_DATA_W-1:0] w;
		kind = $urandom_range(99);
		if (kind < 70) begin
			y1 = $urandom_range(1, 9999);
			gap = $urandom_range(99);
			if (gap < 25)
				y2 = y1;
			else if (gap < 45)
				y2 = y1 + 1;
			else if (gap < 55)
				y2 = $urandom_range(1, 9999);
			else
				y2 = $urandom_range(y1, 9999);
			return pack_dates(y1, $urandom_range(1, 12), $urandom_range(1, 31),
				y2, $urandom_range(1, 12), $urandom_range(1, 31));
		end
		if (kind < 85)
			return pack_dates($urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 16383),
				$urandom_range(0, 15), $urandom_range(0, 31));
		w = S_DATA_W'({$urandom, $urandom});
		w[S_DATA_W-1:S_USED_W] = '0;
		return w;
	endfunction

	// offer one date word, with a random gap first, until it is taken
	task automatic send_dates(input logic [S_DATA_W-1:0] word);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = s_tready;
			@(negedge clk);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: leap rules, year order, odd month and day codes, extremes
		send_dates(pack_dates(2024, 1, 1, 2024, 1, 1));
		send_dates(pack_dates(2024, 1, 1, 2024, 12, 31));
		send_dates(pack_dates(2023, 1, 1, 2023, 12, 31));
		send_dates(pack_dates(2000, 2, 28, 2000, 3, 1));
		send_dates(pack_dates(1900, 2, 28, 1900, 3, 1));
		send_dates(pack_dates(2023, 12, 31, 2024, 3, 1));
		send_dates(pack_dates(2024, 6, 15, 2023, 6, 15));
		send_dates(pack_dates(1, 1, 1, 9999, 12, 31));
		send_dates(pack_dates(0, 1, 1, 16383, 12, 31));
		send_dates(pack_dates(0, 2, 28, 0, 3, 1));
		send_dates(pack_dates(2021, 0, 5, 2021, 3, 5));
		send_dates(pack_dates(2021, 13, 1, 2021, 15, 9));
		send_dates(pack_dates(2021, 15, 31, 2022, 13, 0));
		send_dates(pack_dates(2021, 11, 31, 2021, 2, 0));
		send_dates(pack_dates(2021, 4, 31, 2021, 5, 0));
		send_dates(pack_dates(1999, 3, 1, 2001, 3, 1));
		send_dates(pack_dates(16383, 12, 31, 16383, 1, 1));
		send_dates(pack_dates(1, 15, 0, 16383, 0, 31));
		send_dates(pack_dates(8191, 7, 16, 8192, 8, 15));
		send_dates(pack_dates(2100, 2, 29, 2101, 1, 1));
		send_dates(pack_dates(400, 1, 1, 800, 1, 1));
		send_dates(pack_dates(16383, 1, 1, 0, 12, 31));

		// sender mostly busy, receiver mostly stalled
		repeat (ITEMS_PER_PHASE) send_dates(random_dates());

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 78;
		recv_idle_pct = 6;
		repeat (ITEMS_PER_PHASE) send_dates(random_dates());

		// back to back on both sides
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (ITEMS_PER_PHASE) send_dates(random_dates());
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
